FILE: rtl/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared widths, hue offsets and the dominant-channel sector type for the
// RGB to HSV converter and its checker.
// ----------------------------------------------------------------------------
package r2h_pkg;

   localparam int SAT_FRAC_BITS_DEF = 15;

   localparam int CH_W  = 8;   // input channel and brightness width
   localparam int HUE_W = 9;   // hue in whole degrees
   localparam int SAT_W = 16;  // saturation field width

   // 60 * |diff| fits in 14 bits; its quotient by delta never exceeds 60
   localparam int HUE_NUM_W = 14;
   localparam int HUE_Q_W   = 6;

   localparam int HUE_MAX = 359;

   localparam logic [HUE_W-1:0] HUE_RED_BASE   = 9'd0;
   localparam logic [HUE_W-1:0] HUE_RED_WRAP   = 9'd360;
   localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
   localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 9'd240;

   // which channel holds the maximum (red wins ties, then green)
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

endpackage

FILE: rtl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Pipelined RGB to HSV pixel converter, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage: drive req_red/green/blue and pulse start; busy is always low, so a
// new pixel transaction can be issued on every clock. Each pixel produces
// exactly one result, shown on the rsp_ ports for a single cycle with
// rsp_valid high. The receiver cannot stall the block, so results must
// be taken as they appear. The saturation divider is a restoring divider
// unrolled one quotient bit per pipeline stage, with SAT_FRAC_BITS + 1
// stages. Hue is computed by a second, 6-bit divider that rides in the
// first six of those stages. Results come out in order.
//
// Pipeline:
//   s1   input register
//   s2   max / min search and choice of the dominant channel (sector)
//   s3   delta = max - min, signed channel difference, hue numerator 60*|d|
//   d0.. one quotient bit per stage for saturation (delta / max) and, in the
//        first six stages, for hue (60*|d| / delta)
//   out  hue offset add (with ceiling for negative differences), grey and
//        black pixel overrides
// ----------------------------------------------------------------------------
module rgb_to_hsv #(
   parameter int SAT_FRAC_BITS = r2h_pkg::SAT_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [r2h_pkg::CH_W-1:0]   req_red,
   input  logic [r2h_pkg::CH_W-1:0]   req_green,
   input  logic [r2h_pkg::CH_W-1:0]   req_blue,
   output logic                       rsp_valid,
   output logic [r2h_pkg::HUE_W-1:0]  rsp_hue,
   output logic [r2h_pkg::SAT_W-1:0]  rsp_saturation,
   output logic [r2h_pkg::CH_W-1:0]   rsp_brightness
);

   localparam int CH_W      = r2h_pkg::CH_W;
   localparam int HUE_W     = r2h_pkg::HUE_W;
   localparam int SAT_W     = r2h_pkg::SAT_W;
   localparam int HUE_NUM_W = r2h_pkg::HUE_NUM_W;
   localparam int HUE_Q_W   = r2h_pkg::HUE_Q_W;
   localparam int DIV_STEPS = SAT_FRAC_BITS + 1;  // saturation quotient bits
   localparam int SQ_W      = SAT_FRAC_BITS + 1;

   // fully pipelined, never refuses a transaction
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------- s1
   logic            s1_vld_ff;
   logic [CH_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_red_ff   <= req_red;
      s1_green_ff <= req_green;
      s1_blue_ff  <= req_blue;
   end

   // ---------------------------------------------------------------- s2
   // max, min and the dominant channel; up/down are the operands of the
   // channel difference for that sector
   logic                s2_vld_ff;
   logic [CH_W-1:0]     s2_max_ff, s2_min_ff, s2_up_ff, s2_down_ff;
   r2h_pkg::sector_type s2_sect_ff;

   logic [CH_W-1:0]     s2_max_in, s2_min_in, s2_up_in, s2_down_in;
   r2h_pkg::sector_type s2_sect_in;

   always_comb begin
      logic [CH_W-1:0] gb_max;
      logic [CH_W-1:0] gb_min;
      gb_max = (s1_green_ff >= s1_blue_ff) ? s1_green_ff : s1_blue_ff;
      gb_min = (s1_green_ff <= s1_blue_ff) ? s1_green_ff : s1_blue_ff;
      s2_max_in = (s1_red_ff >= gb_max) ? s1_red_ff : gb_max;
      s2_min_in = (s1_red_ff <= gb_min) ? s1_red_ff : gb_min;
      if (s1_red_ff >= gb_max) begin
         s2_sect_in = r2h_pkg::SECT_RED;
         s2_up_in   = s1_green_ff;
         s2_down_in = s1_blue_ff;
      end else if (s1_green_ff >= s1_blue_ff) begin
         s2_sect_in = r2h_pkg::SECT_GREEN;
         s2_up_in   = s1_blue_ff;
         s2_down_in = s1_red_ff;
      end else begin
         s2_sect_in = r2h_pkg::SECT_BLUE;
         s2_up_in   = s1_red_ff;
         s2_down_in = s1_green_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_max_ff  <= s2_max_in;
      s2_min_ff  <= s2_min_in;
      s2_up_ff   <= s2_up_in;
      s2_down_ff <= s2_down_in;
      s2_sect_ff <= s2_sect_in;
   end

   // ---------------------------------------------------------------- s3
   // Per-stage divider state, index 0 is the s3 output, index k+1 the
   // output of divider step k.
   logic                 dv_vld_ff   [0:DIV_STEPS];
   logic [CH_W-1:0]      dv_max_ff   [0:DIV_STEPS];
   logic [CH_W-1:0]      dv_delta_ff [0:DIV_STEPS];
   logic [CH_W-1:0]      dv_srem_ff  [0:DIV_STEPS];
   logic [SQ_W-1:0]      dv_sq_ff    [0:DIV_STEPS];
   logic [HUE_NUM_W-1:0] dv_hrem_ff  [0:DIV_STEPS];
   logic [HUE_Q_W-1:0]   dv_hq_ff    [0:DIV_STEPS];
   logic                 dv_neg_ff   [0:DIV_STEPS];
   r2h_pkg::sector_type  dv_sect_ff  [0:DIV_STEPS];

   logic [CH_W-1:0]      s3_delta_in;
   logic                 s3_neg_in;
   logic [HUE_NUM_W-1:0] s3_num_in;

   always_comb begin
      logic [CH_W-1:0]      diff_mag;
      logic [HUE_NUM_W-1:0] mag_ext;
      s3_delta_in = s2_max_ff - s2_min_ff;
      s3_neg_in   = s2_up_ff < s2_down_ff;
      diff_mag    = s3_neg_in ? (s2_down_ff - s2_up_ff) : (s2_up_ff - s2_down_ff);
      mag_ext     = {{(HUE_NUM_W-CH_W){1'b0}}, diff_mag};
      // 60 * |diff| = 64*|diff| - 4*|diff|
      s3_num_in   = (mag_ext << 6) - (mag_ext << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dv_max_ff[0]   <= s2_max_ff;
      dv_delta_ff[0] <= s3_delta_in;
      dv_srem_ff[0]  <= s3_delta_in;   // saturation dividend starts as delta
      dv_sq_ff[0]    <= '0;
      dv_hrem_ff[0]  <= s3_num_in;
      dv_hq_ff[0]    <= '0;
      dv_neg_ff[0]   <= s3_neg_in;
      dv_sect_ff[0]  <= s2_sect_ff;
   end

   // ---------------------------------------------------------- divider
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [CH_W:0]        trial;
      logic                 sbit;
      logic [CH_W-1:0]      srem_in;
      logic [HUE_NUM_W-1:0] hrem_in;
      logic [HUE_Q_W-1:0]   hq_in;

      // saturation: first step tests delta >= max (pure color gives 2^F),
      // later steps shift the remainder left by one
      always_comb begin
         logic [CH_W:0] diff9;
         if (k == 0) begin
            trial = {1'b0, dv_srem_ff[k]};
         end else begin
            trial = {dv_srem_ff[k], 1'b0};
         end
         sbit    = trial >= {1'b0, dv_max_ff[k]};
         diff9   = trial - {1'b0, dv_max_ff[k]};
         srem_in = sbit ? diff9[CH_W-1:0] : trial[CH_W-1:0];
      end

      if (k < HUE_Q_W) begin : g_hue
         // hue: quotient bit HUE_Q_W-1-k against delta shifted up
         always_comb begin
            logic [HUE_NUM_W-1:0] dsh;
            logic                 hbit;
            dsh     = {{(HUE_NUM_W-CH_W){1'b0}}, dv_delta_ff[k]} << (HUE_Q_W - 1 - k);
            hbit    = dv_hrem_ff[k] >= dsh;
            hrem_in = hbit ? (dv_hrem_ff[k] - dsh) : dv_hrem_ff[k];
            hq_in   = {dv_hq_ff[k][HUE_Q_W-2:0], hbit};
         end
      end else begin : g_hue_hold
         assign hrem_in = dv_hrem_ff[k];
         assign hq_in   = dv_hq_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         dv_max_ff[k+1]   <= dv_max_ff[k];
         dv_delta_ff[k+1] <= dv_delta_ff[k];
         dv_srem_ff[k+1]  <= srem_in;
         dv_sq_ff[k+1]    <= {dv_sq_ff[k][SQ_W-2:0], sbit};
         dv_hrem_ff[k+1]  <= hrem_in;
         dv_hq_ff[k+1]    <= hq_in;
         dv_neg_ff[k+1]   <= dv_neg_ff[k];
         dv_sect_ff[k+1]  <= dv_sect_ff[k];
      end
   end

   // ---------------------------------------------------------- output
   logic             out_vld_ff;
   logic [HUE_W-1:0] out_hue_ff;
   logic [SAT_W-1:0] out_sat_ff;
   logic [CH_W-1:0]  out_val_ff;

   logic [HUE_W-1:0] out_hue_in;
   logic [SAT_W-1:0] out_sat_in;

   always_comb begin
      logic [HUE_W-1:0]      base;
      logic [HUE_W-1:0]      q_floor;
      logic [HUE_W-1:0]      q_ceil;
      logic [SQ_W+SAT_W-1:0] sq_ext;
      case (dv_sect_ff[DIV_STEPS])
         r2h_pkg::SECT_RED:   base = dv_neg_ff[DIV_STEPS] ? r2h_pkg::HUE_RED_WRAP
                                                          : r2h_pkg::HUE_RED_BASE;
         r2h_pkg::SECT_GREEN: base = r2h_pkg::HUE_GREEN_BASE;
         r2h_pkg::SECT_BLUE:  base = r2h_pkg::HUE_BLUE_BASE;
         default:             base = r2h_pkg::HUE_RED_BASE;
      endcase
      q_floor = {{(HUE_W-HUE_Q_W){1'b0}}, dv_hq_ff[DIV_STEPS]};
      // negative difference: floor(-x) = -ceil(x)
      q_ceil  = q_floor + {{(HUE_W-1){1'b0}}, (dv_hrem_ff[DIV_STEPS] != '0)};
      if (dv_delta_ff[DIV_STEPS] == '0) begin
         out_hue_in = '0;                       // grey pixel
      end else if (dv_neg_ff[DIV_STEPS]) begin
         out_hue_in = base - q_ceil;
      end else begin
         out_hue_in = base + q_floor;
      end
      sq_ext = {{SAT_W{1'b0}}, dv_sq_ff[DIV_STEPS]};
      if (dv_max_ff[DIV_STEPS] == '0) begin
         out_sat_in = '0;                       // black pixel
      end else begin
         out_sat_in = sq_ext[SAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      out_hue_ff <= out_hue_in;
      out_sat_ff <= out_sat_in;
      out_val_ff <= dv_max_ff[DIV_STEPS];
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_hue        = out_hue_ff;
   assign rsp_saturation = out_sat_ff;
   assign rsp_brightness = out_val_ff;

endmodule

FILE: rtl/r2h_checker.sv
// ----------------------------------------------------------------------------
// r2h_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module r2h_checker #(
   parameter int SAT_FRAC_BITS = r2h_pkg::SAT_FRAC_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [r2h_pkg::HUE_W-1:0]  rsp_hue,
   input logic [r2h_pkg::SAT_W-1:0]  rsp_saturation,
   input logic [r2h_pkg::CH_W-1:0]   rsp_brightness
);

   localparam int LATENCY = SAT_FRAC_BITS + 5;

   // every result traces back to a transaction a fixed number of edges ago
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching transaction");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue <= r2h_pkg::HUE_W'(r2h_pkg::HUE_MAX)))
      else $error("hue out of range");

   // black pixel has no saturation
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brightness == '0) |-> (rsp_saturation == '0))
      else $error("saturation set on black pixel");

   // zero saturation means a grey pixel, whose hue is zero
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturation == '0) |-> (rsp_hue == '0))
      else $error("hue set on grey pixel");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("transaction refused");

endmodule

bind rgb_to_hsv r2h_checker #(
   .SAT_FRAC_BITS (SAT_FRAC_BITS)
) u_r2h_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_brightness (rsp_brightness)
);
